// ----- rtl/hlrs_pkg.sv -----
// Shared types, constants and helper functions for the histogram longest-run span finder.
package hlrs_pkg;

    // Sizing of the bin stream.
    localparam int MAX_BINS   = 256;
    localparam int COUNT_BITS = 8;
    localparam int IDX_BITS   = $clog2(MAX_BINS);
    localparam int POS_BITS   = IDX_BITS + 1;
    localparam int SAT_BITS   = 9;
    localparam int CFG_BITS   = 8;

    typedef logic [IDX_BITS-1:0]          idx_t;
    typedef logic signed [POS_BITS-1:0]   pos_t;
    typedef logic signed [POS_BITS:0]     diff_t;
    typedef logic [COUNT_BITS-1:0]        cnt_t;
    typedef logic [COUNT_BITS+3:0]        wsum_t;
    typedef logic [SAT_BITS-1:0]          sat_t;
    typedef logic [CFG_BITS-1:0]          cfg_t;

    // Scan axis carried on tuser.
    typedef enum logic {
        AXIS_ROW    = 1'b0,
        AXIS_COLUMN = 1'b1
    } axis_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_ROW_THRESHOLD    = 2'd0;
    localparam logic [1:0] REG_COLUMN_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_BRIDGE_LIMIT     = 2'd2;

    // Reset values of the configuration registers.
    localparam cfg_t ROW_THRESHOLD_RST    = cfg_t'(6);
    localparam cfg_t COLUMN_THRESHOLD_RST = cfg_t'(4);
    localparam cfg_t BRIDGE_LIMIT_RST     = cfg_t'(2);

    // Markers and limits.
    localparam pos_t  POS_NONE = '1;
    localparam sat_t  SAT_MAX  = '1;
    localparam sat_t  GAP_OPEN = sat_t'(2);
    localparam idx_t  IDX_MAX  = idx_t'(MAX_BINS - 1);
    localparam diff_t DIFF_ONE = diff_t'(1);

    // A bin qualifies when field >= T or 9*field + line >= 10*T.
    function automatic logic qualifies(cnt_t f, cnt_t l, cnt_t t);
        wsum_t lhs;
        wsum_t rhs;
        lhs = (wsum_t'(f) << 3) + wsum_t'(f) + wsum_t'(l);
        rhs = (wsum_t'(t) << 3) + (wsum_t'(t) << 1);
        return (f >= t) || (lhs >= rhs);
    endfunction

    // Length of a span as end minus start, one bit wider to stay exact.
    function automatic diff_t span_len(pos_t s, pos_t e);
        return diff_t'(e) - diff_t'(s);
    endfunction

    // A run replaces the best span when it is at least as long.
    function automatic logic offer_wins(pos_t s, pos_t e, pos_t bs, pos_t be);
        return span_len(s, e) >= span_len(bs, be);
    endfunction

    // Bin index as a signed span position.
    function automatic pos_t to_pos(idx_t idx);
        return pos_t'({1'b0, idx});
    endfunction

endpackage

// ----- rtl/histogram_longest_run_span.sv -----
// Longest-run span finder over a stream of histogram bins, row and column scans.
//
// Input channel s_*: one histogram bin per transfer. s_tuser selects the scan
// (0 row scan with bridging, 1 column scan), s_tlast marks the final bin of a
// scan. Output channel m_*: one result per scan, sent after its final bin,
// carrying the best span and a found flag; m_tuser gives the scan axis.
// The configuration port writes a threshold or the bridge limit at any edge
// with cfg_we high; the user must write it only while no bins are in flight,
// which the block does not enforce. Throughput is one bin per cycle while no
// closing bin waits: the input register feeds a single stage of compare and
// counter logic that updates the scan state and the result register that drives m_tvalid.
// When the receiver stalls, bins that close no scan keep flowing; a closing bin
// waits in the input register until the result register is free, and s_tready
// then drops. Row and column scans keep separate state and may be interleaved.
// Reset clears both scans, the pipeline valids and restores the default
// configuration (row threshold 6, column threshold 4, bridge limit 2).
module histogram_longest_run_span
    import hlrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // Bin input: tdata = field_count[7:0], line_count[15:8].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    // tuser = mode[0].
    input  logic        s_tuser,
    input  logic        s_tlast,
    // Result: tdata = span_start[8:0], span_end[17:9], span_found[18], zero[23:19].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    // tuser = scan_axis[0].
    output logic        m_tuser
);

    // Configuration registers.
    cfg_t row_threshold_reg, column_threshold_reg, bridge_limit_reg;

    // Input register.
    logic  in_valid_reg, in_valid_next;
    axis_t in_mode_reg;
    cnt_t  in_field_reg, in_line_reg;
    logic  in_last_reg;

    // Result register.
    logic  out_valid_reg, out_valid_next;
    axis_t out_axis_reg, out_axis_next;
    pos_t  out_start_reg, out_start_next;
    pos_t  out_end_reg, out_end_next;
    logic  out_found_reg, out_found_next;

    // Row scan state.
    idx_t idx_row_reg, idx_row_next;
    pos_t run_start_row_reg, run_start_row_next;
    pos_t run_end_row_reg, run_end_row_next;
    pos_t best_start_row_reg, best_start_row_next;
    pos_t best_end_row_reg, best_end_row_next;
    sat_t bridge_count_reg, bridge_count_next;
    sat_t gap_count_reg, gap_count_next;

    // Column scan state.
    idx_t idx_col_reg, idx_col_next;
    pos_t run_start_col_reg, run_start_col_next;
    pos_t run_end_col_reg, run_end_col_next;
    pos_t best_start_col_reg, best_start_col_next;
    pos_t best_end_col_reg, best_end_col_next;

    logic out_free;
    logic proceed;
    logic in_fire;

    // Handshake: a closing bin needs a free result register, other bins never wait.
    assign out_free = !out_valid_reg || m_tready;
    assign proceed  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || proceed;
    assign in_fire  = s_tvalid && s_tready;

    assign in_valid_next = in_fire || (in_valid_reg && !proceed);

    // Output ports.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_axis_reg;
    assign m_tdata  = {5'b0, out_found_reg, out_end_reg, out_start_reg};

    // Scan update for the bin in the input register.
    always_comb
    begin
        idx_row_next        = idx_row_reg;
        run_start_row_next  = run_start_row_reg;
        run_end_row_next    = run_end_row_reg;
        best_start_row_next = best_start_row_reg;
        best_end_row_next   = best_end_row_reg;
        bridge_count_next   = bridge_count_reg;
        gap_count_next      = gap_count_reg;
        idx_col_next        = idx_col_reg;
        run_start_col_next  = run_start_col_reg;
        run_end_col_next    = run_end_col_reg;
        best_start_col_next = best_start_col_reg;
        best_end_col_next   = best_end_col_reg;

        out_valid_next = out_valid_reg && !m_tready;
        out_axis_next  = out_axis_reg;
        out_start_next = out_start_reg;
        out_end_next   = out_end_reg;
        out_found_next = out_found_reg;

        if (proceed)
        begin
            if (in_mode_reg == AXIS_ROW)
            begin
                // Row scan: extend, bridge over line-colour bins, or count a gap.
                if (qualifies(in_field_reg, in_line_reg, row_threshold_reg)
                    && (bridge_count_reg <= sat_t'(bridge_limit_reg)))
                begin
                    gap_count_next = '0;
                    if (in_field_reg >= row_threshold_reg)
                    begin
                        bridge_count_next = '0;
                    end
                    if (run_start_row_reg == POS_NONE)
                    begin
                        run_start_row_next = to_pos(idx_row_reg);
                    end
                    run_end_row_next = to_pos(idx_row_reg);
                end
                else if ((in_line_reg >= row_threshold_reg)
                         && (span_len(run_start_row_reg, run_end_row_reg) > DIFF_ONE))
                begin
                    if (bridge_count_reg != SAT_MAX)
                    begin
                        bridge_count_next = bridge_count_reg + sat_t'(1);
                    end
                    gap_count_next = '0;
                end
                else
                begin
                    if (gap_count_reg > GAP_OPEN)
                    begin
                        if (offer_wins(run_start_row_reg, run_end_row_reg,
                                       best_start_row_reg, best_end_row_reg))
                        begin
                            best_start_row_next = run_start_row_reg;
                            best_end_row_next   = run_end_row_reg;
                            bridge_count_next   = '0;
                        end
                        run_start_row_next = POS_NONE;
                        run_end_row_next   = POS_NONE;
                    end
                    if (gap_count_reg != SAT_MAX)
                    begin
                        gap_count_next = gap_count_reg + sat_t'(1);
                    end
                end

                if (idx_row_reg != IDX_MAX)
                begin
                    idx_row_next = idx_row_reg + idx_t'(1);
                end

                // Closing bin: final offer, emit, then return the row scan to reset.
                if (in_last_reg)
                begin
                    if (offer_wins(run_start_row_next, run_end_row_next,
                                   best_start_row_next, best_end_row_next))
                    begin
                        best_start_row_next = run_start_row_next;
                        best_end_row_next   = run_end_row_next;
                    end
                    out_valid_next = 1'b1;
                    out_axis_next  = AXIS_ROW;
                    out_start_next = best_start_row_next;
                    out_end_next   = best_end_row_next;
                    out_found_next = !best_start_row_next[POS_BITS-1]
                                     && !best_end_row_next[POS_BITS-1];

                    idx_row_next        = '0;
                    run_start_row_next  = POS_NONE;
                    run_end_row_next    = POS_NONE;
                    best_start_row_next = '0;
                    best_end_row_next   = '0;
                    bridge_count_next   = '0;
                    gap_count_next      = '0;
                end
            end
            else
            begin
                // Column scan: extend on a qualifying bin, otherwise offer the run.
                if (qualifies(in_field_reg, in_line_reg, column_threshold_reg))
                begin
                    if (run_start_col_reg == POS_NONE)
                    begin
                        run_start_col_next = to_pos(idx_col_reg);
                    end
                    run_end_col_next = to_pos(idx_col_reg);
                end
                else if (offer_wins(run_start_col_reg, run_end_col_reg,
                                    best_start_col_reg, best_end_col_reg))
                begin
                    best_start_col_next = run_start_col_reg;
                    best_end_col_next   = run_end_col_reg;
                end

                if (idx_col_reg != IDX_MAX)
                begin
                    idx_col_next = idx_col_reg + idx_t'(1);
                end

                // Closing bin: final offer, emit, then return the column scan to reset.
                if (in_last_reg)
                begin
                    if (offer_wins(run_start_col_next, run_end_col_next,
                                   best_start_col_next, best_end_col_next))
                    begin
                        best_start_col_next = run_start_col_next;
                        best_end_col_next   = run_end_col_next;
                    end
                    out_valid_next = 1'b1;
                    out_axis_next  = AXIS_COLUMN;
                    out_start_next = best_start_col_next;
                    out_end_next   = best_end_col_next;
                    out_found_next = !best_start_col_next[POS_BITS-1]
                                     && !best_end_col_next[POS_BITS-1];

                    idx_col_next        = '0;
                    run_start_col_next  = POS_NONE;
                    run_end_col_next    = POS_NONE;
                    best_start_col_next = '0;
                    best_end_col_next   = '0;
                end
            end
        end
    end

    // Control, scan state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_threshold_reg    <= ROW_THRESHOLD_RST;
            column_threshold_reg <= COLUMN_THRESHOLD_RST;
            bridge_limit_reg     <= BRIDGE_LIMIT_RST;
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            idx_row_reg          <= '0;
            run_start_row_reg    <= POS_NONE;
            run_end_row_reg      <= POS_NONE;
            best_start_row_reg   <= '0;
            best_end_row_reg     <= '0;
            bridge_count_reg     <= '0;
            gap_count_reg        <= '0;
            idx_col_reg          <= '0;
            run_start_col_reg    <= POS_NONE;
            run_end_col_reg      <= POS_NONE;
            best_start_col_reg   <= '0;
            best_end_col_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ROW_THRESHOLD:    row_threshold_reg    <= cfg_data;
                    REG_COLUMN_THRESHOLD: column_threshold_reg <= cfg_data;
                    REG_BRIDGE_LIMIT:     bridge_limit_reg     <= cfg_data;
                    default:              ;
                endcase
            end
            in_valid_reg       <= in_valid_next;
            out_valid_reg      <= out_valid_next;
            idx_row_reg        <= idx_row_next;
            run_start_row_reg  <= run_start_row_next;
            run_end_row_reg    <= run_end_row_next;
            best_start_row_reg <= best_start_row_next;
            best_end_row_reg   <= best_end_row_next;
            bridge_count_reg   <= bridge_count_next;
            gap_count_reg      <= gap_count_next;
            idx_col_reg        <= idx_col_next;
            run_start_col_reg  <= run_start_col_next;
            run_end_col_reg    <= run_end_col_next;
            best_start_col_reg <= best_start_col_next;
            best_end_col_reg   <= best_end_col_next;
        end
    end

    // Payload registers for the input bin and the result.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_mode_reg  <= axis_t'(s_tuser);
            in_field_reg <= s_tdata[COUNT_BITS-1:0];
            in_line_reg  <= s_tdata[2*COUNT_BITS-1:COUNT_BITS];
            in_last_reg  <= s_tlast;
        end
        out_axis_reg  <= out_axis_next;
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
        out_found_reg <= out_found_next;
    end

endmodule
